### src/mips_integer_execute_unit_macros.svh
// Assertion macros for the integer execute unit checker.
`ifndef MIPS_INTEGER_EXECUTE_UNIT_MACROS_SVH
`define MIPS_INTEGER_EXECUTE_UNIT_MACROS_SVH
// Assert an implication in the same cycle.
`define MIEU_ASSERT_NOW(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);
// Assert an implication in the next cycle.
`define MIEU_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`endif

### src/mieu_pkg.sv
// Package with command codes, state and control types for the integer execute unit.
`default_nettype none
package mieu_pkg;
  typedef enum logic [4:0] {
    CMD_SLL = 5'd0, CMD_SRL = 5'd1, CMD_SRA = 5'd2, CMD_SLT = 5'd3, CMD_SLTU = 5'd4,
    CMD_SLTI = 5'd5, CMD_SLTIU = 5'd6, CMD_AND = 5'd7, CMD_ANDI = 5'd8, CMD_ORI = 5'd9,
    CMD_OR = 5'd10, CMD_MULT = 5'd11, CMD_DIVU = 5'd12, CMD_ADDI = 5'd13,
    CMD_ADDU = 5'd14, CMD_ADDIU = 5'd15, CMD_DADDU = 5'd16, CMD_DADDI = 5'd17,
    CMD_MFHI = 5'd18, CMD_MFLO = 5'd19, CMD_SYNC = 5'd20, CMD_SUBU = 5'd21,
    CMD_MOVN = 5'd22
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_EXEC, ST_MUL, ST_DIV, ST_DONE
  } state_t;

  // Start and completion signals between sequencer and the multiply/divide unit.
  typedef struct packed {
    logic start_mul;
    logic start_div;
  } md_ctrl_t;

  typedef struct packed {
    logic done;
  } md_stat_t;

  function automatic logic [63:0] sext32(input logic [31:0] v);
    sext32 = {{32{v[31]}}, v};
  endfunction

  function automatic logic [63:0] sext16(input logic [15:0] v);
    sext16 = {{48{v[15]}}, v};
  endfunction
endpackage
`default_nettype wire

### src/mips_integer_execute_unit.sv
// Top level of the integer execute unit: sequencer, register file, ALU and multiply/divide.
`default_nettype none
// One word is taken when start is high and busy is low; its result appears for one cycle
// with done high and cannot be stalled. Register file reads go through two ports of the
// 32x64 register RAM; every command passes the read and execute states (register write in
// execute); mult and divu with a nonzero divisor then go to the bit-serial multiply/divide unit.
// The register file is cleared after reset over all 32 entries, while busy is high.
module mips_integer_execute_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output      logic        busy,
  input  wire logic [4:0]  command,
  input  wire logic [4:0]  source_index,
  input  wire logic [4:0]  target_index,
  input  wire logic [4:0]  dest_index,
  input  wire logic [4:0]  shift_amount,
  input  wire logic [15:0] immediate,
  output      logic        done,
  output      logic        reg_write,
  output      logic [4:0]  write_index,
  output      logic [63:0] write_value,
  output      logic        hilo_write,
  output      logic [63:0] hi_value,
  output      logic [63:0] lo_value
);
  import mieu_pkg::*;

  state_t      state;
  state_t      state_next;
  logic        clearing;
  logic [4:0]  clr_idx;
  cmd_t        cmd;
  logic [4:0]  rs_q;
  logic [4:0]  rt_q;
  logic [4:0]  rd_q;
  logic [4:0]  sa_q;
  logic [15:0] imm_q;
  logic [63:0] a;
  logic [63:0] b;
  logic [63:0] alu_res;
  logic [63:0] hi_reg;
  logic [63:0] lo_reg;
  logic        we;
  logic [4:0]  waddr;
  logic [63:0] wdata;
  md_ctrl_t    md_ctrl;
  md_stat_t    md_stat;
  logic [31:0] md_hi;
  logic [31:0] md_lo;
  logic        wr_c;
  logic [4:0]  widx_c;
  logic [63:0] val_c;

  mieu_ram #(.Width(64), .Depth(32)) u_rf_a (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(rs_q), .rdata(a)
  );
  mieu_ram #(.Width(64), .Depth(32)) u_rf_b (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(rt_q), .rdata(b)
  );

  mieu_alu u_alu (
    .cmd(cmd), .a(a), .b(b), .sa(sa_q), .imm(imm_q), .result(alu_res)
  );

  mieu_muldiv u_md (
    .clk(clk), .rst(rst), .ctrl(md_ctrl), .op_a(a[31:0]), .op_b(b[31:0]),
    .stat(md_stat), .res_hi(md_hi), .res_lo(md_lo)
  );

  always_comb begin
    wr_c   = 1'b0;
    widx_c = rd_q;
    val_c  = alu_res;
    unique case (cmd) inside
      CMD_SLL, CMD_SRL, CMD_SRA, CMD_SLT, CMD_SLTU, CMD_AND, CMD_OR,
      CMD_ADDU, CMD_DADDU, CMD_SUBU: wr_c = 1'b1;
      CMD_SLTI, CMD_SLTIU, CMD_ANDI, CMD_ORI, CMD_ADDI, CMD_ADDIU, CMD_DADDI: begin
        wr_c   = 1'b1;
        widx_c = rt_q;
      end
      CMD_MFHI: begin
        wr_c  = 1'b1;
        val_c = hi_reg;
      end
      CMD_MFLO: begin
        wr_c  = 1'b1;
        val_c = lo_reg;
      end
      CMD_MOVN: wr_c = (b != 64'd0);
      default: wr_c = 1'b0;
    endcase
  end

  always_comb begin
    we    = clearing;
    waddr = clr_idx;
    wdata = '0;
    if (!clearing && state == ST_EXEC && wr_c) begin
      we    = 1'b1;
      waddr = widx_c;
      wdata = val_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_idx <= clr_idx + 5'd1;
        if (clr_idx == 5'd31) begin
          clearing <= 1'b0;
        end
      end
    end
  end

  always_comb begin
    state_next = state;
    md_ctrl    = '0;
    unique case (state)
      ST_IDLE: if (start && !busy) state_next = ST_READ;
      ST_READ: state_next = ST_EXEC;
      ST_EXEC: begin
        if (cmd == CMD_MULT) begin
          md_ctrl.start_mul = 1'b1;
          state_next        = ST_MUL;
        end else if (cmd == CMD_DIVU && b[31:0] != 32'd0) begin
          md_ctrl.start_div = 1'b1;
          state_next        = ST_DIV;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_MUL, ST_DIV: if (md_stat.done) state_next = ST_DONE;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  assign busy = clearing || (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start && !busy) begin
      cmd   <= cmd_t'(command);
      rs_q  <= source_index;
      rt_q  <= target_index;
      rd_q  <= dest_index;
      sa_q  <= shift_amount;
      imm_q <= immediate;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hi_reg      <= '0;
      lo_reg      <= '0;
      done        <= 1'b0;
      hilo_write  <= 1'b0;
      reg_write   <= 1'b0;
      write_index <= '0;
      write_value <= '0;
    end else begin
      done       <= 1'b0;
      hilo_write <= 1'b0;
      if (state == ST_EXEC && state_next == ST_IDLE) begin
        done        <= 1'b1;
        reg_write   <= wr_c;
        write_index <= wr_c ? widx_c : 5'd0;
        write_value <= wr_c ? val_c : 64'd0;
      end
      if ((state == ST_MUL || state == ST_DIV) && md_stat.done) begin
        hi_reg <= sext32(md_hi);
        lo_reg <= sext32(md_lo);
      end
      if (state == ST_DONE) begin
        done        <= 1'b1;
        hilo_write  <= 1'b1;
        reg_write   <= 1'b0;
        write_index <= '0;
        write_value <= '0;
      end
    end
  end

  assign hi_value = hi_reg;
  assign lo_value = lo_reg;
endmodule
`default_nettype wire

### src/mieu_ram.sv
// Generic single-port-write, one-port-read RAM with registered read.
`default_nettype none
module mieu_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output      logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### src/mieu_muldiv.sv
// Iterative shared multiply/divide unit: one bit of the operation per cycle.
`default_nettype none
module mieu_muldiv (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire mieu_pkg::md_ctrl_t  ctrl,
  input  wire logic [31:0]         op_a,
  input  wire logic [31:0]         op_b,
  output      mieu_pkg::md_stat_t  stat,
  output      logic [31:0]         res_hi,
  output      logic [31:0]         res_lo
);
  import mieu_pkg::*;

  logic        busy;
  logic        is_div;
  logic [5:0]  count;
  logic [63:0] acc;
  logic [63:0] mcand;
  logic [31:0] mplier;
  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dvsr;
  logic [32:0] rem_shift;
  logic [32:0] rem_diff;

  assign rem_shift = {rem, quo[31]};
  assign rem_diff  = rem_shift - {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      stat     <= '0;
      count    <= '0;
      is_div   <= 1'b0;
    end else begin
      stat.done <= 1'b0;
      if (ctrl.start_mul || ctrl.start_div) begin
        busy   <= 1'b1;
        is_div <= ctrl.start_div;
        count  <= 6'd32;
      end else if (busy) begin
        count <= count - 6'd1;
        if (count == 6'd1) begin
          busy      <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start_mul || ctrl.start_div) begin
      acc    <= '0;
      mcand  <= sext32(op_a);
      mplier <= op_b;
      rem    <= '0;
      quo    <= op_a;
      dvsr   <= op_b;
    end else if (busy) begin
      if (is_div) begin
        if (!rem_diff[32]) begin
          rem <= rem_diff[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= rem_shift[31:0];
          quo <= {quo[30:0], 1'b0};
        end
      end else begin
        // Signed multiplier: bit 31 carries negative weight.
        if (mplier[0]) begin
          if (count == 6'd1) begin
            acc <= acc - mcand;
          end else begin
            acc <= acc + mcand;
          end
        end
        mcand  <= {mcand[62:0], 1'b0};
        mplier <= {1'b0, mplier[31:1]};
      end
    end
  end

  assign res_hi = is_div ? rem : acc[63:32];
  assign res_lo = is_div ? quo : acc[31:0];
endmodule
`default_nettype wire

### src/mieu_alu.sv
// Combinational ALU for shifts, compares, logic, adds, subtracts and the movn pass-through.
`default_nettype none
module mieu_alu (
  input  wire mieu_pkg::cmd_t cmd,
  input  wire logic [63:0]    a,
  input  wire logic [63:0]    b,
  input  wire logic [4:0]     sa,
  input  wire logic [15:0]    imm,
  output      logic [63:0]    result
);
  import mieu_pkg::*;

  logic [63:0] imm_s;
  logic [31:0] sum32;
  logic [31:0] sum32i;
  logic [31:0] diff32;

  assign imm_s  = sext16(imm);
  assign sum32  = a[31:0] + b[31:0];
  assign sum32i = a[31:0] + imm_s[31:0];
  assign diff32 = a[31:0] - b[31:0];

  always_comb begin
    result = '0;
    case (cmd)
      CMD_SLL:   result = sext32(b[31:0] << sa);
      CMD_SRL:   result = sext32(b[31:0] >> sa);
      CMD_SRA:   result = sext32(32'($signed(b[31:0]) >>> sa));
      CMD_SLT:   result = {63'd0, $signed(a) < $signed(b)};
      CMD_SLTU:  result = {63'd0, a < b};
      CMD_SLTI:  result = {63'd0, $signed(a) < $signed(imm_s)};
      CMD_SLTIU: result = {63'd0, a < imm_s};
      CMD_AND:   result = a & b;
      CMD_ANDI:  result = a & {48'd0, imm};
      CMD_ORI:   result = a | {48'd0, imm};
      CMD_OR:    result = a | b;
      CMD_ADDI, CMD_ADDIU: result = sext32(sum32i);
      CMD_ADDU:  result = sext32(sum32);
      CMD_DADDU: result = a + b;
      CMD_DADDI: result = a + imm_s;
      CMD_SUBU:  result = sext32(diff32);
      CMD_MOVN:  result = a;
      default:   result = '0;
    endcase
  end
endmodule
`default_nettype wire

### src/mieu_checker.sv
// Port-level checker for the integer execute unit, bound to the top level.
`default_nettype none
`include "mips_integer_execute_unit_macros.svh"
module mieu_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic        reg_write,
  input wire logic [4:0]  write_index,
  input wire logic [63:0] write_value,
  input wire logic        hilo_write,
  input wire logic [63:0] hi_value,
  input wire logic [63:0] lo_value
);
  `MIEU_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy did not rise after accept")
  `MIEU_ASSERT_NOW(a_nowrite_zero, done && !reg_write, write_index == 5'd0 && write_value == 64'd0, "idle write fields not zero")
  `MIEU_ASSERT_NEXT(a_hilo_stable, !busy, $stable(hi_value) && $stable(lo_value), "HI or LO changed while idle")
  `MIEU_ASSERT_NOW(a_excl, done, !(reg_write && hilo_write), "reg_write and hilo_write together")
endmodule

bind mips_integer_execute_unit mieu_checker u_mieu_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .reg_write(reg_write),
  .write_index(write_index), .write_value(write_value), .hilo_write(hilo_write),
  .hi_value(hi_value), .lo_value(lo_value)
);
`default_nettype wire
